/* rtl/contiguous_block_fit_allocator_assert.svh */
// assertion helpers used by the checker module cbfa_chk
`ifndef CONTIGUOUS_BLOCK_FIT_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_BLOCK_FIT_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CBFA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define CBFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/cbfa_pkg.sv */
package cbfa_pkg;

    // field widths of the channels
    localparam int CMD_W         = 1;
    localparam int BLOCK_INDEX_W = 5;
    localparam int ITEM_SIZE_W   = 16;
    localparam int STATUS_W      = 2;

    // configuration port
    localparam int POLICY_W      = 2;
    localparam int BLOCK_COUNT_W = 6;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 6;

    localparam logic [CFG_INDEX_W-1:0] REG_FIT_POLICY  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 1'd1;

    localparam logic [POLICY_W-1:0]      POLICY_RESET = 2'd0;
    localparam logic [BLOCK_COUNT_W-1:0] COUNT_RESET  = 6'd32;

    // commands
    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

    // fit policies
    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] STATUS_LOADED    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_FIT    = 2'd2;

    // sequencer program counter and jump conditions
    localparam int PC_W   = 2;
    localparam int COND_W = 3;

    localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd0;
    localparam logic [COND_W-1:0] COND_ACCEPT   = 3'd1;
    localparam logic [COND_W-1:0] COND_SKIP     = 3'd2;
    localparam logic [COND_W-1:0] COND_MORE     = 3'd3;
    localparam logic [COND_W-1:0] COND_OUT_FREE = 3'd4;

    // program steps
    localparam logic [PC_W-1:0] STEP_IDLE  = 2'd0;
    localparam logic [PC_W-1:0] STEP_PRIME = 2'd1;
    localparam logic [PC_W-1:0] STEP_SCAN  = 2'd2;
    localparam logic [PC_W-1:0] STEP_EMIT  = 2'd3;

    // condition flags from the datapath
    typedef struct packed {
        logic accept;
        logic skip_scan;
        logic scan_more;
        logic out_free;
    } cbfa_cond_t;

    // one control word of the program
    typedef struct packed {
        logic              take;
        logic              rd;
        logic              eval;
        logic              emit;
        logic              hold;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } cbfa_cw_t;

    localparam int PROG_DEPTH = 4;

    // jump to target when cond holds, else stay on hold, else step on
    localparam cbfa_cw_t PROGRAM [PROG_DEPTH] = '{
        '{take: 1'b1, rd: 1'b0, eval: 1'b0, emit: 1'b0, hold: 1'b1,
          cond: COND_ACCEPT,   target: STEP_PRIME},
        '{take: 1'b0, rd: 1'b1, eval: 1'b0, emit: 1'b0, hold: 1'b0,
          cond: COND_SKIP,     target: STEP_EMIT},
        '{take: 1'b0, rd: 1'b1, eval: 1'b1, emit: 1'b0, hold: 1'b0,
          cond: COND_MORE,     target: STEP_SCAN},
        '{take: 1'b0, rd: 1'b0, eval: 1'b0, emit: 1'b1, hold: 1'b1,
          cond: COND_OUT_FREE, target: STEP_IDLE}
    };

endpackage

/* rtl/contiguous_block_fit_allocator.sv */
// Contiguous block fit allocator.
// Input channel (in_valid / in_stall): one beat is a command. A load beat
// (cmd 0) writes item_size into block block_index and frees that block; an
// allocate beat (cmd 1) asks for item_size and picks a free block by the
// configured policy (first, best or worst fit, lowest index on a tie).
// Output channel (out_valid / out_stall): one result beat per input beat,
// carrying status, chosen_block, chosen_size and leftover.
// Config channel (cfg_valid / cfg_ready): index 0 fit_policy, index 1
// block_count; write only while no command is in flight.
// Steps: a load goes from accept through prime and emit back to idle; an
// allocate adds one scan step per block scanned (at most the smaller
// of block_count and NUM_BLOCKS, fewer under first fit once a block fits).
// The scan reads the size memory one entry per cycle through its single
// read port. The result sits in an output register, so the next command is
// taken while a stalled result waits; a new result is only written when
// that register is empty or being taken.
// Reset: all blocks free, policy first fit, block_count 32; block sizes are
// undefined until loaded.
module contiguous_block_fit_allocator #(
    parameter int NUM_BLOCKS = 32,
    parameter int SIZE_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // command channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [cbfa_pkg::CMD_W-1:0]            cmd,
    input  logic [cbfa_pkg::BLOCK_INDEX_W-1:0]    block_index,
    input  logic [cbfa_pkg::ITEM_SIZE_W-1:0]      item_size,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [cbfa_pkg::STATUS_W-1:0]         status,
    output logic [cbfa_pkg::BLOCK_INDEX_W-1:0]    chosen_block,
    output logic [cbfa_pkg::ITEM_SIZE_W-1:0]      chosen_size,
    output logic [cbfa_pkg::ITEM_SIZE_W-1:0]      leftover,
    // config channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cbfa_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [cbfa_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import cbfa_pkg::*;

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int LIM_W = (CNT_W > BLOCK_COUNT_W) ? CNT_W : BLOCK_COUNT_W;

    cbfa_cw_t   cw;
    cbfa_cond_t cond;

    // configuration
    logic [POLICY_W-1:0]      policy_reg;
    logic [BLOCK_COUNT_W-1:0] count_reg;

    // command held during the scan
    logic [CMD_W-1:0]     cmd_reg;
    logic [SIZE_BITS-1:0] req_reg;

    // size memory and used flags
    logic [SIZE_BITS-1:0]  size_mem [NUM_BLOCKS];
    logic [SIZE_BITS-1:0]  rd_data_reg;
    logic [NUM_BLOCKS-1:0] used_reg;

    // scan state
    logic [CNT_W-1:0]     rd_ptr_reg;
    logic [IDX_W-1:0]     eval_idx_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     pick_idx_reg;
    logic [SIZE_BITS-1:0] pick_size_reg;
    logic [SIZE_BITS-1:0] pick_left_reg;

    // output register
    logic                     out_valid_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic [BLOCK_INDEX_W-1:0] chosen_block_reg;
    logic [ITEM_SIZE_W-1:0]   chosen_size_reg;
    logic [ITEM_SIZE_W-1:0]   leftover_reg;

    logic                 accept;
    logic                 load_hit;
    logic [LIM_W-1:0]     count_ext;
    logic [LIM_W-1:0]     limit;
    logic                 scan_last;
    logic                 rd_en;
    logic                 fits;
    logic [SIZE_BITS-1:0] left;
    logic                 is_best;
    logic                 is_worst;
    logic                 better;
    logic                 pick_en;
    logic                 out_free;
    logic                 emit_fire;

    cbfa_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .cw    (cw)
    );

    // handshakes
    assign in_stall  = !cw.take;
    assign accept    = in_valid && cw.take;
    assign cfg_ready = 1'b1;
    assign load_hit  = accept && (cmd == CMD_LOAD) && (32'(block_index) < NUM_BLOCKS);
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_fire = cw.emit && out_free;

    // scan bound, clipped to the table
    assign count_ext = LIM_W'(count_reg);
    assign limit     = (count_ext > LIM_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS) : count_ext;
    assign scan_last = (LIM_W'(eval_idx_reg) + LIM_W'(1)) >= limit;
    assign rd_en     = cw.rd && (LIM_W'(rd_ptr_reg) < LIM_W'(NUM_BLOCKS));

    // fit test and policy compare on the entry just read
    assign is_best  = (policy_reg == POLICY_BEST);
    assign is_worst = (policy_reg == POLICY_WORST);
    assign fits     = !used_reg[eval_idx_reg] && (rd_data_reg >= req_reg);
    assign left     = rd_data_reg - req_reg;
    assign better   = !found_reg
                   || (is_best && (left < pick_left_reg))
                   || (is_worst && (left > pick_left_reg));
    assign pick_en  = cw.eval && fits && better;

    // jump conditions
    assign cond.accept    = accept;
    assign cond.skip_scan = (cmd_reg == CMD_LOAD) || (limit == '0);
    assign cond.scan_more = !scan_last
                         && !(!is_best && !is_worst && (found_reg || fits));
    assign cond.out_free  = out_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_RESET;
            count_reg  <= COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FIT_POLICY:  policy_reg <= POLICY_W'(cfg_data);
                REG_BLOCK_COUNT: count_reg  <= BLOCK_COUNT_W'(cfg_data);
                default:         ;
            endcase
        end
    end

    // size memory: load writes, scan reads
    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            size_mem[IDX_W'(block_index)] <= SIZE_BITS'(item_size);
        end
        if (rd_en)
        begin
            rd_data_reg <= size_mem[rd_ptr_reg[IDX_W-1:0]];
        end
    end

    // used flags: freed by load, claimed on a successful allocate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (load_hit)
        begin
            used_reg[IDX_W'(block_index)] <= 1'b0;
        end
        else if (emit_fire && (cmd_reg == CMD_ALLOC) && found_reg)
        begin
            used_reg[pick_idx_reg] <= 1'b1;
        end
    end

    // command latch and found flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= CMD_LOAD;
            found_reg <= 1'b0;
        end
        else if (accept)
        begin
            cmd_reg   <= cmd;
            found_reg <= 1'b0;
        end
        else if (pick_en)
        begin
            found_reg <= 1'b1;
        end
    end

    // scan pointers and current pick
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg    <= SIZE_BITS'(item_size);
            rd_ptr_reg <= '0;
        end
        else if (cw.rd)
        begin
            rd_ptr_reg   <= rd_ptr_reg + CNT_W'(1);
            eval_idx_reg <= rd_ptr_reg[IDX_W-1:0];
        end
        if (pick_en)
        begin
            pick_idx_reg  <= eval_idx_reg;
            pick_size_reg <= rd_data_reg;
            pick_left_reg <= left;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            if (cmd_reg == CMD_LOAD)
            begin
                status_reg       <= STATUS_LOADED;
                chosen_block_reg <= '0;
                chosen_size_reg  <= '0;
                leftover_reg     <= '0;
            end
            else if (found_reg)
            begin
                status_reg       <= STATUS_ALLOCATED;
                chosen_block_reg <= BLOCK_INDEX_W'(pick_idx_reg);
                chosen_size_reg  <= ITEM_SIZE_W'(pick_size_reg);
                leftover_reg     <= ITEM_SIZE_W'(pick_left_reg);
            end
            else
            begin
                status_reg       <= STATUS_NO_FIT;
                chosen_block_reg <= '0;
                chosen_size_reg  <= '0;
                leftover_reg     <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign chosen_block = chosen_block_reg;
    assign chosen_size  = chosen_size_reg;
    assign leftover     = leftover_reg;

endmodule

/* rtl/cbfa_seq.sv */
module cbfa_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  cbfa_pkg::cbfa_cond_t cond,
    output cbfa_pkg::cbfa_cw_t   cw
);
    import cbfa_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            cond_hit;

    // control word of the current step
    assign cw = PROGRAM[pc_reg];

    // jump condition select
    always_comb
    begin
        unique case (cw.cond)
            COND_ALWAYS:   cond_hit = 1'b1;
            COND_ACCEPT:   cond_hit = cond.accept;
            COND_SKIP:     cond_hit = cond.skip_scan;
            COND_MORE:     cond_hit = cond.scan_more;
            COND_OUT_FREE: cond_hit = cond.out_free;
            default:       cond_hit = 1'b0;
        endcase
    end

    // next step
    always_comb
    begin
        if (cond_hit)
        begin
            pc_next = cw.target;
        end
        else if (cw.hold)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* rtl/cbfa_chk.sv */
`include "contiguous_block_fit_allocator_assert.svh"

module cbfa_chk (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic [cbfa_pkg::STATUS_W-1:0]         status,
    input logic [cbfa_pkg::BLOCK_INDEX_W-1:0]    chosen_block,
    input logic [cbfa_pkg::ITEM_SIZE_W-1:0]      chosen_size,
    input logic [cbfa_pkg::ITEM_SIZE_W-1:0]      leftover
);
    import cbfa_pkg::*;

    logic [STATUS_W+BLOCK_INDEX_W+2*ITEM_SIZE_W-1:0] out_payload;
    logic                                            rest_zero;

    // whole result payload and its all-zero check
    assign out_payload = {status, chosen_block, chosen_size, leftover};
    assign rest_zero   = (chosen_block == '0) && (chosen_size == '0) && (leftover == '0);

    // a stalled result beat holds its payload
    `CBFA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_payload))

    // only an allocated result carries a block, size and leftover
    `CBFA_ASSERT_IMP(a_zero_fields, out_valid && (status != STATUS_ALLOCATED), rest_zero)

    // a command is worked on before the next one is taken
    `CBFA_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

endmodule

bind contiguous_block_fit_allocator cbfa_chk u_cbfa_chk (.*);

/* tb/sv/contiguous_block_fit_allocator_test.sv */
`timescale 1ns / 1ps

module contiguous_block_fit_allocator_test;

    import cbfa_pkg::*;

    localparam int TABLE_DEPTH     = 32;
    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 85;
    localparam int PRESSURE_PHASE  = 4;
    localparam int PRESSURE_CYCLES = 300;
    localparam int QUIET_LIMIT     = 2000;
    localparam int END_CYCLES      = 50;

    // spare policy code, handled as first fit
    localparam logic [POLICY_W-1:0] POLICY_SPARE = 2'd3;

    // one result beat
    typedef struct packed {
        logic [STATUS_W-1:0]      code;
        logic [BLOCK_INDEX_W-1:0] blk;
        logic [ITEM_SIZE_W-1:0]   size;
        logic [ITEM_SIZE_W-1:0]   rest;
    } alloc_result_t;

    // one directed command with the settings it runs under
    typedef struct packed {
        logic [POLICY_W-1:0]      policy;
        logic [BLOCK_COUNT_W-1:0] count;
        logic [CMD_W-1:0]         op;
        logic [BLOCK_INDEX_W-1:0] idx;
        logic [ITEM_SIZE_W-1:0]   size;
        logic                     typed;
        alloc_result_t            want;
    } stim_row_t;

    localparam alloc_result_t RES_LOADED = '{STATUS_LOADED, 5'd0, 16'd0, 16'd0};
    localparam alloc_result_t RES_NO_FIT = '{STATUS_NO_FIT, 5'd0, 16'd0, 16'd0};
    localparam alloc_result_t RES_MODEL  = '0;

    localparam stim_row_t DIRECTED_ROWS [24] = '{
        // table of four blocks, first fit
        '{POLICY_FIRST, 6'd4, CMD_LOAD,  5'd0,  16'd100,   1'b1, RES_LOADED},
        '{POLICY_FIRST, 6'd4, CMD_LOAD,  5'd1,  16'hFFFF,  1'b1, RES_LOADED},
        '{POLICY_FIRST, 6'd4, CMD_LOAD,  5'd2,  16'd0,     1'b1, RES_LOADED},
        '{POLICY_FIRST, 6'd4, CMD_LOAD,  5'd3,  16'd100,   1'b1, RES_LOADED},
        '{POLICY_FIRST, 6'd4, CMD_ALLOC, 5'd31, 16'd0,     1'b1,
          '{STATUS_ALLOCATED, 5'd0, 16'd100, 16'd100}},
        '{POLICY_FIRST, 6'd4, CMD_ALLOC, 5'd0,  16'hFFFF,  1'b1,
          '{STATUS_ALLOCATED, 5'd1, 16'hFFFF, 16'd0}},
        '{POLICY_FIRST, 6'd4, CMD_ALLOC, 5'd0,  16'hFFFF,  1'b1, RES_NO_FIT},
        '{POLICY_FIRST, 6'd4, CMD_ALLOC, 5'd0,  16'd0,     1'b1,
          '{STATUS_ALLOCATED, 5'd2, 16'd0, 16'd0}},
        '{POLICY_FIRST, 6'd4, CMD_ALLOC, 5'd0,  16'd50,    1'b1,
          '{STATUS_ALLOCATED, 5'd3, 16'd100, 16'd50}},
        // every block taken
        '{POLICY_FIRST, 6'd4, CMD_ALLOC, 5'd0,  16'd0,     1'b1, RES_NO_FIT},
        // reload frees the blocks, two equal sizes for a tie
        '{POLICY_FIRST, 6'd4, CMD_LOAD,  5'd0,  16'd30,    1'b1, RES_LOADED},
        '{POLICY_FIRST, 6'd4, CMD_LOAD,  5'd1,  16'd200,   1'b1, RES_LOADED},
        '{POLICY_FIRST, 6'd4, CMD_LOAD,  5'd2,  16'd40,    1'b1, RES_LOADED},
        '{POLICY_FIRST, 6'd4, CMD_LOAD,  5'd3,  16'd40,    1'b1, RES_LOADED},
        '{POLICY_BEST,  6'd4, CMD_ALLOC, 5'd0,  16'd35,    1'b0, RES_MODEL},
        '{POLICY_BEST,  6'd4, CMD_ALLOC, 5'd0,  16'd35,    1'b0, RES_MODEL},
        // worst fit, then an exact fit under worst fit
        '{POLICY_WORST, 6'd4, CMD_ALLOC, 5'd0,  16'd30,    1'b0, RES_MODEL},
        '{POLICY_WORST, 6'd4, CMD_ALLOC, 5'd0,  16'd30,    1'b0, RES_MODEL},
        // spare policy code
        '{POLICY_SPARE, 6'd4, CMD_LOAD,  5'd1,  16'd500,   1'b1, RES_LOADED},
        '{POLICY_SPARE, 6'd4, CMD_LOAD,  5'd2,  16'd500,   1'b1, RES_LOADED},
        '{POLICY_SPARE, 6'd4, CMD_ALLOC, 5'd0,  16'd10,    1'b0, RES_MODEL},
        // zero count scans nothing
        '{POLICY_BEST,  6'd0, CMD_ALLOC, 5'd0,  16'd0,     1'b1, RES_NO_FIT},
        '{POLICY_WORST, 6'd1, CMD_LOAD,  5'd0,  16'd7,     1'b1, RES_LOADED},
        '{POLICY_WORST, 6'd1, CMD_ALLOC, 5'd0,  16'd7,     1'b0, RES_MODEL}
    };

    localparam logic [POLICY_W-1:0] PHASE_POLICY [PHASES] = '{
        POLICY_FIRST, POLICY_BEST, POLICY_WORST, POLICY_SPARE,
        POLICY_BEST, POLICY_WORST, POLICY_FIRST, POLICY_SPARE
    };
    localparam logic [BLOCK_COUNT_W-1:0] PHASE_COUNT [PHASES] = '{
        6'd32, 6'd63, 6'd1, 6'd12, 6'd32, 6'd0, 6'd6, 6'd32
    };

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [CMD_W-1:0]         cmd;
    logic [BLOCK_INDEX_W-1:0] block_index;
    logic [ITEM_SIZE_W-1:0]   item_size;
    logic                     out_valid;
    logic                     out_stall;
    logic [STATUS_W-1:0]      status;
    logic [BLOCK_INDEX_W-1:0] chosen_block;
    logic [ITEM_SIZE_W-1:0]   chosen_size;
    logic [ITEM_SIZE_W-1:0]   leftover;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    // mirror of the allocation table and settings
    logic [ITEM_SIZE_W-1:0]   block_size_tab [TABLE_DEPTH];
    logic                     block_taken [TABLE_DEPTH];
    logic [POLICY_W-1:0]      fit_mode   = POLICY_RESET;
    logic [BLOCK_COUNT_W-1:0] scan_count = COUNT_RESET;

    alloc_result_t awaited_results [$];
    int  fault_count    = 0;
    int  send_gap_pct   = 0;
    int  recv_stall_pct = 0;
    bit  pressure_req   = 1'b0;

    contiguous_block_fit_allocator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .block_index  (block_index),
        .item_size    (item_size),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .chosen_block (chosen_block),
        .chosen_size  (chosen_size),
        .leftover     (leftover),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // table update and outcome of one command
    function automatic alloc_result_t apply_command(input logic [CMD_W-1:0] op,
                                                    input logic [BLOCK_INDEX_W-1:0] idx,
                                                    input logic [ITEM_SIZE_W-1:0] req);
        alloc_result_t          res;
        int                     span;
        int                     k;
        int                     pick;
        bit                     found;
        logic [ITEM_SIZE_W-1:0] slack;
        logic [ITEM_SIZE_W-1:0] pick_slack;
        res        = '0;
        pick       = 0;
        found      = 1'b0;
        pick_slack = '0;
        if (op == CMD_LOAD)
        begin
            block_size_tab[idx] = req;
            block_taken[idx]    = 1'b0;
            res.code            = STATUS_LOADED;
            return res;
        end
        span = (scan_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(scan_count);
        for (k = 0; k < span; k++)
        begin
            if (!block_taken[k] && block_size_tab[k] >= req)
            begin
                slack = block_size_tab[k] - req;
                if (!found)
                begin
                    found      = 1'b1;
                    pick       = k;
                    pick_slack = slack;
                    if (fit_mode != POLICY_BEST && fit_mode != POLICY_WORST)
                        break;
                end
                else if (fit_mode == POLICY_BEST && slack < pick_slack)
                begin
                    pick       = k;
                    pick_slack = slack;
                end
                else if (fit_mode == POLICY_WORST && slack > pick_slack)
                begin
                    pick       = k;
                    pick_slack = slack;
                end
            end
        end
        if (!found)
        begin
            res.code = STATUS_NO_FIT;
            return res;
        end
        block_taken[pick] = 1'b1;
        res.code = STATUS_ALLOCATED;
        res.blk  = BLOCK_INDEX_W'(pick);
        res.size = block_size_tab[pick];
        res.rest = pick_slack;
        return res;
    endfunction

    // sizes cluster on a coarse grid so best and worst fit see ties
    function automatic logic [ITEM_SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return ITEM_SIZE_W'($urandom);
            default: return ITEM_SIZE_W'($urandom_range(0, 15) * 16);
        endcase
    endfunction

    // present one command beat and hold it until taken
    task automatic drive_beat(input logic [CMD_W-1:0] op,
                              input logic [BLOCK_INDEX_W-1:0] idx,
                              input logic [ITEM_SIZE_W-1:0] sz,
                              input logic typed,
                              input alloc_result_t want);
        alloc_result_t outcome;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= op;
        block_index <= idx;
        item_size   <= sz;
        do @(posedge clk); while (in_stall);
        outcome = apply_command(op, idx, sz);
        awaited_results.push_back(typed ? want : outcome);
    endtask

    // stop offering and wait for every result to come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // write both registers back to back
    task automatic load_settings(input logic [POLICY_W-1:0] pol,
                                 input logic [BLOCK_COUNT_W-1:0] cnt);
        cfg_valid <= 1'b1;
        cfg_index <= REG_FIT_POLICY;
        cfg_data  <= CFG_DATA_W'(pol);
        do @(posedge clk); while (!cfg_ready);
        fit_mode = pol;
        cfg_index <= REG_BLOCK_COUNT;
        cfg_data  <= CFG_DATA_W'(cnt);
        do @(posedge clk); while (!cfg_ready);
        scan_count = cnt;
        cfg_valid <= 1'b0;
    endtask

    task automatic compare_field(input string what,
                                 input logic [ITEM_SIZE_W-1:0] want,
                                 input logic [ITEM_SIZE_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fault_count++;
        end
    endtask

    // result side: check each beat, stall at random or for a long hold
    initial
    begin
        alloc_result_t want;
        int            hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result beat, expected none, actual status %0d block %0d",
                             $time, status, chosen_block);
                    fault_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("status", ITEM_SIZE_W'(want.code), ITEM_SIZE_W'(status));
                    compare_field("chosen_block", ITEM_SIZE_W'(want.blk),
                                  ITEM_SIZE_W'(chosen_block));
                    compare_field("chosen_size", want.size, chosen_size);
                    compare_field("leftover", want.rest, leftover);
                end
            end
            if (pressure_req)
            begin
                hold_left    = PRESSURE_CYCLES;
                pressure_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // watchdog on cycles with no beat on any channel
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[contiguous_block_fit_allocator] ERROR");
        $finish;
    end

    // stimulus
    initial
    begin
        int i;
        int ph;
        int mode;
        in_valid    <= 1'b0;
        cmd         <= CMD_LOAD;
        block_index <= '0;
        item_size   <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_FIT_POLICY;
        cfg_data    <= '0;
        rst_n       <= 1'b0;
        for (i = 0; i < TABLE_DEPTH; i++)
            block_taken[i] = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, settings changed only when the row asks
        foreach (DIRECTED_ROWS[r])
        begin
            if (DIRECTED_ROWS[r].policy != fit_mode || DIRECTED_ROWS[r].count != scan_count)
            begin
                wait_drained();
                load_settings(DIRECTED_ROWS[r].policy, DIRECTED_ROWS[r].count);
            end
            drive_beat(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].size,
                       DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
        end

        // give every block a size so full-width scans only see loaded entries
        for (i = 0; i < TABLE_DEPTH; i++)
            drive_beat(CMD_LOAD, BLOCK_INDEX_W'(i), pick_size(), 1'b0, RES_MODEL);

        // random phases over policies, counts and idling patterns
        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            load_settings(PHASE_POLICY[ph], PHASE_COUNT[ph]);
            mode           = ph % 4;
            send_gap_pct   = (mode == 1) ? 68 : (mode == 3) ? 31 : 0;
            recv_stall_pct = (mode == 2) ? 68 : (mode == 3) ? 31 : 0;
            if (ph == PRESSURE_PHASE)
                pressure_req = 1'b1;
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 45)
                    drive_beat(CMD_LOAD, BLOCK_INDEX_W'($urandom_range(0, 31)), pick_size(),
                               1'b0, RES_MODEL);
                else
                    drive_beat(CMD_ALLOC, BLOCK_INDEX_W'($urandom_range(0, 31)), pick_size(),
                               1'b0, RES_MODEL);
            end
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (fault_count == 0 && awaited_results.size() == 0)
            $display("[contiguous_block_fit_allocator] OK");
        else
            $display("[contiguous_block_fit_allocator] ERROR");
        $finish;
    end

endmodule
